// File: design/onoff_keyed_frame_serializer_assert.svh
// ----------------------------------------------------------------------------
// onoff_keyed_frame_serializer_assert.svh
// Assertion macros used by the serializer's port checker.
// ----------------------------------------------------------------------------
`ifndef ONOFF_KEYED_FRAME_SERIALIZER_ASSERT_SVH
`define ONOFF_KEYED_FRAME_SERIALIZER_ASSERT_SVH

// Checked while out of reset
`define OKFS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Checked on every edge, reset included
`define OKFS_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// File: design/okfs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// okfs_pkg
// Types and constants for the on-off keyed frame serializer.
// ----------------------------------------------------------------------------
package okfs_pkg;

    localparam int BYTE_W = 8;
    localparam int POS_W  = 11;   // bit position in the frame
    localparam int TOT_W  = 12;   // frame bit count, up to 2048
    localparam int LEN_W  = 9;    // frame_length register
    localparam int CNT_W  = 32;
    localparam int MODE_W = 2;
    localparam int KIND_W = 2;
    localparam int BIT_W  = 3;    // bit index inside a byte

    typedef enum logic [MODE_W-1:0] {
        MODE_OFF    = 2'd0,
        MODE_CONT   = 2'd1,
        MODE_TEST   = 2'd2,
        MODE_SINGLE = 2'd3
    } mode_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_TICK = 2'd0,
        KIND_LOAD = 2'd1,
        KIND_MODE = 2'd2
    } kind_t;

    // Register index on the APB port
    localparam logic REG_FRAME_LENGTH = 1'b0;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [BYTE_W-1:0] byte_address;
        logic [BYTE_W-1:0] byte_value;
        logic [MODE_W-1:0] new_mode;
    } item_t;

    typedef struct packed {
        logic              carrier_on;
        logic              frame_done;
        logic [CNT_W-1:0]  frame_count;
        logic [MODE_W-1:0] mode_now;
    } result_t;

    // Frame store write request
    typedef struct packed {
        logic              en;
        logic [BYTE_W-1:0] addr;
        logic [BYTE_W-1:0] data;
    } mem_wr_t;

endpackage

// File: design/okfs_frame_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// okfs_frame_mem
// Frame byte store: one write port, one registered read port with
// write-through, plus a shadow of byte 0 for restarts after a length change.
// ----------------------------------------------------------------------------
module okfs_frame_mem #(
    parameter int FRAME_BYTES = 256,
    parameter int ADDR_W      = 8
) (
    input  logic                          aclk,
    input  okfs_pkg::mem_wr_t             wr,
    input  logic [ADDR_W-1:0]             rd_addr,
    output logic [okfs_pkg::BYTE_W-1:0]   rd_data,
    output logic [okfs_pkg::BYTE_W-1:0]   byte0
);

    logic [okfs_pkg::BYTE_W-1:0] mem [FRAME_BYTES];
    logic [okfs_pkg::BYTE_W-1:0] rd_data_reg;
    logic [okfs_pkg::BYTE_W-1:0] byte0_reg;
    logic [ADDR_W-1:0]           wr_addr;

    assign wr_addr = wr.addr[ADDR_W-1:0];

    // write port
    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr_addr] <= wr.data;
        end
    end

    // read port, new data wins on a same-address write
    always_ff @(posedge aclk) begin
        if (wr.en && (wr_addr == rd_addr)) begin
            rd_data_reg <= wr.data;
        end else begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // byte 0 shadow
    always_ff @(posedge aclk) begin
        if (wr.en && (wr_addr == '0)) begin
            byte0_reg <= wr.data;
        end
    end

    assign rd_data = rd_data_reg;
    assign byte0   = byte0_reg;

endmodule

// File: design/okfs_tx_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// okfs_tx_core
// Serializer state (bit position, mode, frame count, carrier) and the
// single-pass update for one word.
// ----------------------------------------------------------------------------
module okfs_tx_core #(
    parameter int FRAME_BYTES = 256,
    parameter int ADDR_W      = 8
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          fire,
    input  okfs_pkg::item_t               item,
    input  logic [okfs_pkg::LEN_W-1:0]    frame_length,
    input  logic [okfs_pkg::BYTE_W-1:0]   rd_byte,
    input  logic [okfs_pkg::BYTE_W-1:0]   byte0,
    output okfs_pkg::mem_wr_t             wr,
    output logic [ADDR_W-1:0]             rd_addr,
    output okfs_pkg::result_t             res
);

    localparam logic [okfs_pkg::LEN_W-1:0] MAX_BYTES = okfs_pkg::LEN_W'(FRAME_BYTES);

    logic [okfs_pkg::POS_W-1:0]  pos_reg, pos_next;
    okfs_pkg::mode_t             mode_reg, mode_next;
    logic [okfs_pkg::CNT_W-1:0]  cnt_reg, cnt_next;
    logic                        car_reg, car_next;
    logic                        done;

    logic [okfs_pkg::LEN_W-1:0]  nbytes;
    logic [okfs_pkg::TOT_W-1:0]  total;
    logic                        stale;
    logic [okfs_pkg::POS_W-1:0]  pos_eff;
    logic [okfs_pkg::TOT_W-1:0]  pos_inc;
    logic [okfs_pkg::BYTE_W-1:0] cur_byte;
    logic                        addr_ok;

    // active frame size
    assign nbytes   = (frame_length > MAX_BYTES) ? MAX_BYTES : frame_length;
    assign total    = {nbytes, okfs_pkg::BIT_W'(0)};
    assign stale    = {1'b0, pos_reg} >= total;
    assign pos_eff  = stale ? '0 : pos_reg;
    assign cur_byte = stale ? byte0 : rd_byte;
    assign pos_inc  = {1'b0, pos_eff} + okfs_pkg::TOT_W'(1);
    assign addr_ok  = {1'b0, item.byte_address} < okfs_pkg::LEN_W'(FRAME_BYTES);

    // next state for the word in flight
    always_comb begin
        pos_next  = pos_reg;
        mode_next = mode_reg;
        cnt_next  = cnt_reg;
        car_next  = car_reg;
        done      = 1'b0;
        wr.en     = 1'b0;
        wr.addr   = item.byte_address;
        wr.data   = item.byte_value;
        if (fire) begin
            unique case (item.kind)
                okfs_pkg::KIND_TICK: begin
                    if (mode_reg == okfs_pkg::MODE_TEST) begin
                        car_next = 1'b1;
                    end else if (mode_reg == okfs_pkg::MODE_OFF || nbytes == '0) begin
                        car_next = 1'b0;
                    end else begin
                        // MSB first
                        car_next = cur_byte[~pos_eff[okfs_pkg::BIT_W-1:0]];
                        if (pos_inc >= total) begin
                            pos_next = '0;
                            cnt_next = cnt_reg + 1'b1;
                            done     = 1'b1;
                            if (mode_reg == okfs_pkg::MODE_SINGLE) begin
                                mode_next = okfs_pkg::MODE_OFF;
                            end
                        end else begin
                            pos_next = pos_inc[okfs_pkg::POS_W-1:0];
                        end
                    end
                end
                okfs_pkg::KIND_LOAD: begin
                    if (addr_ok) begin
                        wr.en    = 1'b1;
                        pos_next = '0;
                    end
                end
                okfs_pkg::KIND_MODE: begin
                    mode_next = okfs_pkg::mode_t'(item.new_mode);
                    pos_next  = '0;
                    if (item.new_mode == okfs_pkg::MODE_OFF) begin
                        car_next = 1'b0;
                    end else if (item.new_mode == okfs_pkg::MODE_TEST) begin
                        car_next = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // prefetch the byte the next tick needs
    assign rd_addr = pos_next[ADDR_W+okfs_pkg::BIT_W-1:okfs_pkg::BIT_W];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg  <= '0;
            mode_reg <= okfs_pkg::MODE_CONT;
            cnt_reg  <= '0;
            car_reg  <= 1'b0;
        end else begin
            pos_reg  <= pos_next;
            mode_reg <= mode_next;
            cnt_reg  <= cnt_next;
            car_reg  <= car_next;
        end
    end

    assign res.carrier_on  = car_next;
    assign res.frame_done  = done;
    assign res.frame_count = cnt_next;
    assign res.mode_now    = mode_next;

endmodule

// File: design/onoff_keyed_frame_serializer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// onoff_keyed_frame_serializer
// On-off keyed carrier serializer: stream in, one result word per input word.
// ----------------------------------------------------------------------------
// Path: an accepted word goes into the input register, then its state update
//   is registered into the result register.
// Throughput: 1 word per cycle while the result stream is not stalled; the frame byte
//   for the next tick comes from the store's registered read port while the word updates.
// Reset (aresetn low, synchronous): both stages empty, position 0, mode
//   continuous, count 0, carrier low, frame_length 0; frame bytes keep data.
module onoff_keyed_frame_serializer #(
    parameter int FRAME_BYTES = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [7:0] byte_address, [15:8] byte_value, [17:16] new_mode
    input  logic [1:0]  s_tuser,   // [1:0] kind
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [0] carrier_on, [32:1] frame_count, [34:33] mode_now
    output logic        m_tlast,   // frame_done
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int ADDR_W = $clog2(FRAME_BYTES);

    logic                          in_valid_reg;
    okfs_pkg::item_t               in_item_reg;
    logic                          out_valid_reg;
    okfs_pkg::result_t             out_res_reg;
    logic [okfs_pkg::LEN_W-1:0]    len_reg;

    logic                          advance;
    logic                          s_fire;
    okfs_pkg::result_t             res;
    okfs_pkg::mem_wr_t             wr;
    logic [ADDR_W-1:0]             rd_addr;
    logic [okfs_pkg::BYTE_W-1:0]   rd_byte;
    logic [okfs_pkg::BYTE_W-1:0]   byte0;
    logic                          reg_sel;

    // handshake
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_fire   = s_tvalid && s_tready;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_fire) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_item_reg.kind         <= s_tuser;
            in_item_reg.byte_address <= s_tdata[7:0];
            in_item_reg.byte_value   <= s_tdata[15:8];
            in_item_reg.new_mode     <= s_tdata[17:16];
        end
    end

    okfs_tx_core #(
        .FRAME_BYTES (FRAME_BYTES),
        .ADDR_W      (ADDR_W)
    ) u_core (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .fire         (advance),
        .item         (in_item_reg),
        .frame_length (len_reg),
        .rd_byte      (rd_byte),
        .byte0        (byte0),
        .wr           (wr),
        .rd_addr      (rd_addr),
        .res          (res)
    );

    okfs_frame_mem #(
        .FRAME_BYTES (FRAME_BYTES),
        .ADDR_W      (ADDR_W)
    ) u_mem (
        .aclk    (aclk),
        .wr      (wr),
        .rd_addr (rd_addr),
        .rd_data (rd_byte),
        .byte0   (byte0)
    );

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_res_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_res_reg.frame_done;
    assign m_tdata  = {5'd0, out_res_reg.mode_now, out_res_reg.frame_count,
                       out_res_reg.carrier_on};

    // APB register
    assign reg_sel = (paddr[2] == okfs_pkg::REG_FRAME_LENGTH);
    assign pready  = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg <= '0;
        end else if (psel && penable && pwrite && pready && reg_sel) begin
            len_reg <= pwdata[okfs_pkg::LEN_W-1:0];
        end
    end

    assign prdata = reg_sel ? {{(32-okfs_pkg::LEN_W){1'b0}}, len_reg} : 32'd0;

endmodule

// File: design/okfs_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// okfs_checker
// Port-level checks on the serializer's result stream.
// ----------------------------------------------------------------------------
`include "onoff_keyed_frame_serializer_assert.svh"

module okfs_port_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata,
    input logic        m_tlast
);

    logic [okfs_pkg::MODE_W-1:0] mode_now;
    logic                        done_mode_ok;
    logic [40:0]                 m_word;

    assign mode_now     = m_tdata[34:33];
    assign done_mode_ok = (mode_now != okfs_pkg::MODE_SINGLE) &&
                          (mode_now != okfs_pkg::MODE_TEST);
    assign m_word       = {m_tlast, m_tdata};

    // a finished frame never leaves the block in single-frame or test mode
    `OKFS_ASSERT(a_done_mode, m_tvalid && m_tlast |-> done_mode_ok, "frame done in single or test")

    // carrier test mode always shows the carrier on
    `OKFS_ASSERT(a_test_on, m_tvalid && mode_now == okfs_pkg::MODE_TEST |-> m_tdata[0], "test carrier low")

    // a stalled word holds
    `OKFS_ASSERT(a_stall_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_word), "stalled word changed")

    // reset empties the result stage
    `OKFS_ASSERT_RST(a_reset_empty, !aresetn |=> !m_tvalid, "result valid after reset")

endmodule

bind onoff_keyed_frame_serializer okfs_port_checker u_okfs_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
